FILE: hw/rtl/face_removal_vertex_remap_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for face removal with vertex remap
// Shared property wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FACE_REMOVAL_VERTEX_REMAP_DEFINES_SVH
`define FACE_REMOVAL_VERTEX_REMAP_DEFINES_SVH

// same-cycle implication
`define FRVR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frvr assertion failed");

// next-cycle implication
`define FRVR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frvr assertion failed");

`endif

FILE: hw/rtl/frvr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frvr_pkg
// Types and constants shared by the face removal / vertex remap block.
// ---------------------------------------------------------------------------
package frvr_pkg;

    localparam int MAX_VERTICES_DEF = 4096;
    localparam int MAX_FACES_DEF    = 8192;

    localparam int FACE_COUNT_W   = 14;
    localparam int VERTEX_COUNT_W = 13;
    localparam int KIND_W         = 2;
    localparam int REMOVE_W       = 16;
    localparam int VERT_W         = 12;
    localparam int FACE_NUM_W     = 13;
    localparam int STATUS_W       = 2;
    localparam int FRESH_W        = 3;
    localparam int NEW_INDEX_W    = 13;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_MARK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FACE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_VERTEX_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FACE_RANGE  = 2'd2;

    // register select, taken from paddr[2]
    localparam logic REG_FACE_COUNT   = 1'b0;
    localparam logic REG_VERTEX_COUNT = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [REMOVE_W-1:0] remove_index;
        logic [VERT_W-1:0]          corner_a;
        logic [VERT_W-1:0]          corner_b;
        logic [VERT_W-1:0]          corner_c;
    } in_item_t;

    typedef struct packed {
        logic [FACE_NUM_W-1:0] face_number;
        logic                  kept;
        logic [STATUS_W-1:0]   status;
        logic [VERT_W-1:0]     new_corner_a;
        logic [VERT_W-1:0]     new_corner_b;
        logic [VERT_W-1:0]     new_corner_c;
        logic [FRESH_W-1:0]    fresh_mask;
    } out_item_t;

    typedef struct packed {
        logic [FACE_COUNT_W-1:0]   face_count;
        logic [VERTEX_COUNT_W-1:0] vertex_count;
    } cfg_regs_t;

    typedef struct packed {
        logic              valid;
        logic [VERT_W-1:0] index;
    } remap_entry_t;

endpackage

FILE: hw/rtl/face_removal_vertex_remap.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// face_removal_vertex_remap
// Drops faces marked removed and renumbers the corner vertices of kept
// faces densely on first use, through a remap memory with a valid bit.
// ---------------------------------------------------------------------------
// A face beyond face_count is answered straight from ST_IDLE; a removed face or a bad
// vertex index is answered from ST_C0; a kept face steps through ST_C0, ST_C1, ST_C2,
// three corner read-modify-writes on the remap memory. busy holds off new items until
// the state is back in ST_IDLE; marks and other items are taken every cycle while idle.
// Reset and restart run a clearing pass over max(MAX_VERTICES, MAX_FACES) addresses
// (8192 by default), busy high throughout. done is a one-cycle strobe, never stalled.
// ---------------------------------------------------------------------------
`include "face_removal_vertex_remap_defines.svh"

module face_removal_vertex_remap
#(
    parameter int MAX_VERTICES = frvr_pkg::MAX_VERTICES_DEF,
    parameter int MAX_FACES    = frvr_pkg::MAX_FACES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [frvr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [frvr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [frvr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  frvr_pkg::in_item_t                item,
    output logic                              done,
    output frvr_pkg::out_item_t               result
);

    localparam int VA_W      = $clog2(MAX_VERTICES);
    localparam int FA_W      = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int CLR_DEPTH = (MAX_VERTICES > MAX_FACES) ? MAX_VERTICES : MAX_FACES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int VW        = frvr_pkg::VERT_W;
    localparam int NW        = frvr_pkg::NEW_INDEX_W;
    localparam int FW        = frvr_pkg::FACE_COUNT_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_C0    = 5'b00100,
        ST_C1    = 5'b01000,
        ST_C2    = 5'b10000
    } state_t;

    frvr_pkg::cfg_regs_t regs;

    state_t                 state_reg, state_next;
    logic [CLR_W-1:0]       clr_reg, clr_next;
    logic [FW-1:0]          faces_seen_reg, faces_seen_next;
    logic [NW-1:0]          next_new_reg, next_new_next;
    logic                   vert_err_reg, vert_err_next;
    logic [VW-1:0]          new_a_reg, new_a_next;
    logic [VW-1:0]          new_b_reg, new_b_next;
    logic [1:0]             fresh_reg, fresh_next;
    logic                   done_reg, done_next;
    frvr_pkg::in_item_t     item_reg;
    frvr_pkg::out_item_t    result_reg, result_next;
    logic                   item_load;
    logic                   result_load;

    logic                   accept;
    logic                   clr_last;
    logic                   face_avail;
    logic                   mark_ok;
    logic [VW-1:0]          cur_corner;
    logic                   fwd_hit;
    logic [VW-1:0]          fwd_index;
    logic                   cur_fresh;
    logic [VW-1:0]          cur_index;

    // memories
    frvr_pkg::remap_entry_t remap_mem [MAX_VERTICES];
    frvr_pkg::remap_entry_t remap_rd_reg;
    logic                   remap_we;
    logic [VA_W-1:0]        remap_waddr;
    frvr_pkg::remap_entry_t remap_wdata;
    logic [VA_W-1:0]        remap_raddr;

    logic                   mark_mem [MAX_FACES];
    logic                   mark_rd_reg;
    logic                   mark_we;
    logic [FA_W-1:0]        mark_waddr;
    logic                   mark_wdata;
    logic [FA_W-1:0]        mark_raddr;

    function automatic logic vert_in_range(input logic [VW-1:0] c,
                                           input logic [NW-1:0] vcount);
        return ({1'b0, c} < vcount) && (32'(c) < 32'(MAX_VERTICES));
    endfunction

    frvr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (regs)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign clr_last = (clr_reg == CLR_W'(CLR_DEPTH - 1));

    assign face_avail = (faces_seen_reg < regs.face_count)
                     && (32'(faces_seen_reg) < 32'(MAX_FACES));

    assign mark_ok = !item.remove_index[frvr_pkg::REMOVE_W-1]
                  && ({1'b0, item.remove_index[frvr_pkg::REMOVE_W-2:0]}
                      < {2'b00, regs.face_count})
                  && (32'(item.remove_index[frvr_pkg::REMOVE_W-2:0]) < 32'(MAX_FACES));

    // corner under resolution and forwarding from earlier corners of the face
    always_comb
    begin
        cur_corner = item_reg.corner_c;
        fwd_hit    = 1'b0;
        fwd_index  = new_a_reg;
        unique case (state_reg)
            ST_C0:
            begin
                cur_corner = item_reg.corner_a;
            end
            ST_C1:
            begin
                cur_corner = item_reg.corner_b;
                fwd_hit    = (item_reg.corner_b == item_reg.corner_a);
            end
            ST_C2:
            begin
                cur_corner = item_reg.corner_c;
                if (item_reg.corner_c == item_reg.corner_a)
                begin
                    fwd_hit   = 1'b1;
                    fwd_index = new_a_reg;
                end
                else if (item_reg.corner_c == item_reg.corner_b)
                begin
                    fwd_hit   = 1'b1;
                    fwd_index = new_b_reg;
                end
            end
            default: ;
        endcase
    end

    assign cur_fresh = !fwd_hit && !remap_rd_reg.valid;
    assign cur_index = fwd_hit            ? fwd_index :
                       remap_rd_reg.valid ? remap_rd_reg.index :
                                            next_new_reg[VW-1:0];

    // remap memory port control
    always_comb
    begin
        remap_we    = 1'b0;
        remap_waddr = VA_W'(cur_corner);
        remap_wdata.valid = 1'b1;
        remap_wdata.index = next_new_reg[VW-1:0];
        if (state_reg == ST_CLEAR)
        begin
            remap_we    = (32'(clr_reg) < 32'(MAX_VERTICES));
            remap_waddr = VA_W'(clr_reg);
            remap_wdata = '0;
        end
        else if (state_reg == ST_C0)
        begin
            remap_we = cur_fresh && !mark_rd_reg && !vert_err_reg;
        end
        else if (state_reg == ST_C1 || state_reg == ST_C2)
        begin
            remap_we = cur_fresh;
        end
    end

    always_comb
    begin
        remap_raddr = VA_W'(item.corner_a);
        if (state_reg == ST_C0)
        begin
            remap_raddr = VA_W'(item_reg.corner_b);
        end
        else if (state_reg == ST_C1)
        begin
            remap_raddr = VA_W'(item_reg.corner_c);
        end
    end

    // mark memory port control
    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = FA_W'(item.remove_index[frvr_pkg::REMOVE_W-2:0]);
        mark_wdata = 1'b1;
        if (state_reg == ST_CLEAR)
        begin
            mark_we    = (32'(clr_reg) < 32'(MAX_FACES));
            mark_waddr = FA_W'(clr_reg);
            mark_wdata = 1'b0;
        end
        else if (accept && item.kind == frvr_pkg::KIND_MARK)
        begin
            mark_we = mark_ok;
        end
    end

    assign mark_raddr = FA_W'(faces_seen_reg);

    always_ff @(posedge clk)
    begin
        if (remap_we)
        begin
            remap_mem[remap_waddr] <= remap_wdata;
        end
        remap_rd_reg <= remap_mem[remap_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[mark_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        faces_seen_next = faces_seen_reg;
        next_new_next   = next_new_reg;
        vert_err_next   = vert_err_reg;
        new_a_next      = new_a_reg;
        new_b_next      = new_b_reg;
        fresh_next      = fresh_reg;
        done_next       = 1'b0;
        item_load       = 1'b0;
        result_load     = 1'b0;
        result_next     = '0;
        result_next.face_number = faces_seen_reg[frvr_pkg::FACE_NUM_W-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + CLR_W'(1);
                if (clr_last)
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.kind)
                        frvr_pkg::KIND_FACE:
                        begin
                            if (!face_avail)
                            begin
                                done_next          = 1'b1;
                                result_load        = 1'b1;
                                result_next.status = frvr_pkg::STATUS_FACE_RANGE;
                            end
                            else
                            begin
                                item_load     = 1'b1;
                                vert_err_next = !(vert_in_range(item.corner_a, regs.vertex_count)
                                    && vert_in_range(item.corner_b, regs.vertex_count)
                                    && vert_in_range(item.corner_c, regs.vertex_count));
                                state_next    = ST_C0;
                            end
                        end
                        frvr_pkg::KIND_RESTART:
                        begin
                            clr_next        = '0;
                            faces_seen_next = '0;
                            next_new_next   = '0;
                            state_next      = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_C0:
            begin
                if (mark_rd_reg)
                begin
                    done_next       = 1'b1;
                    result_load     = 1'b1;
                    faces_seen_next = faces_seen_reg + FW'(1);
                    state_next      = ST_IDLE;
                end
                else if (vert_err_reg)
                begin
                    done_next          = 1'b1;
                    result_load        = 1'b1;
                    result_next.status = frvr_pkg::STATUS_VERTEX_RANGE;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    new_a_next    = cur_index;
                    fresh_next[0] = cur_fresh;
                    next_new_next = next_new_reg + NW'(cur_fresh);
                    state_next    = ST_C1;
                end
            end
            ST_C1:
            begin
                new_b_next    = cur_index;
                fresh_next[1] = cur_fresh;
                next_new_next = next_new_reg + NW'(cur_fresh);
                state_next    = ST_C2;
            end
            ST_C2:
            begin
                next_new_next            = next_new_reg + NW'(cur_fresh);
                faces_seen_next          = faces_seen_reg + FW'(1);
                done_next                = 1'b1;
                result_load              = 1'b1;
                result_next.kept         = 1'b1;
                result_next.status       = frvr_pkg::STATUS_OK;
                result_next.new_corner_a = new_a_reg;
                result_next.new_corner_b = new_b_reg;
                result_next.new_corner_c = cur_index;
                result_next.fresh_mask   = {cur_fresh, fresh_reg};
                state_next               = ST_IDLE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            faces_seen_reg <= '0;
            next_new_reg   <= '0;
            vert_err_reg   <= 1'b0;
            fresh_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            faces_seen_reg <= faces_seen_next;
            next_new_reg   <= next_new_next;
            vert_err_reg   <= vert_err_next;
            fresh_reg      <= fresh_next;
            done_reg       <= done_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        new_a_reg <= new_a_next;
        new_b_reg <= new_b_next;
        if (item_load)
        begin
            item_reg <= item;
        end
        if (result_load)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `FRVR_ASSERT_IMP(a_drop_clean, done_reg && !result_reg.kept,
        result_reg.fresh_mask == '0 && result_reg.new_corner_a == '0
        && result_reg.new_corner_c == '0)
    `FRVR_ASSERT_IMP(a_kept_ok, done_reg && result_reg.kept,
        result_reg.status == frvr_pkg::STATUS_OK)
    `FRVR_ASSERT_IMP(a_count_fresh, done_reg && result_reg.kept,
        next_new_reg == NW'($past(next_new_reg, 3) + NW'($countones(result_reg.fresh_mask))))
    `FRVR_ASSERT_IMP(a_first_fresh, done_reg && result_reg.kept && result_reg.fresh_mask[0],
        result_reg.new_corner_a == VW'($past(next_new_reg, 3)))
    `FRVR_ASSERT_NXT(a_clear_holds, state_reg == ST_CLEAR && !clr_last,
        state_reg == ST_CLEAR && busy)

endmodule

FILE: hw/rtl/frvr_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frvr_cfg
// APB register file holding face_count and vertex_count.
// ---------------------------------------------------------------------------
module frvr_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [frvr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [frvr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [frvr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output frvr_pkg::cfg_regs_t               regs
);

    frvr_pkg::cfg_regs_t regs_reg;
    frvr_pkg::cfg_regs_t regs_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                frvr_pkg::REG_FACE_COUNT:
                    regs_next.face_count = pwdata[frvr_pkg::FACE_COUNT_W-1:0];
                frvr_pkg::REG_VERTEX_COUNT:
                    regs_next.vertex_count = pwdata[frvr_pkg::VERTEX_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            frvr_pkg::REG_FACE_COUNT:
                prdata = frvr_pkg::CFG_DATA_W'(regs_reg.face_count);
            frvr_pkg::REG_VERTEX_COUNT:
                prdata = frvr_pkg::CFG_DATA_W'(regs_reg.vertex_count);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for face removal with vertex remap. Directed cases hit
// the register extremes, removal marks at the range edges, repeated corners,
// bad vertex indices and faces past the count; random mesh phases then mark
// faces and stream triangles under varying register settings. Every result
// is checked field by field against a behavioral predictor of the block.
// ---------------------------------------------------------------------------
module tb_top;
    import frvr_pkg::*;

    localparam int FACE_LIMIT     = MAX_FACES_DEF;
    localparam int VERTEX_LIMIT   = MAX_VERTICES_DEF;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int STREAM_ITEMS   = 200;

    localparam logic [KIND_W-1:0]     KIND_UNUSED       = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_FACE_COUNT   = {REG_FACE_COUNT, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_VERTEX_COUNT = {REG_VERTEX_COUNT, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    in_item_t              item;
    logic                  done;
    out_item_t             result;

    face_removal_vertex_remap u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result)
    );

    // predictor state
    bit                     face_removed [0:FACE_LIMIT-1];
    bit                     vert_mapped  [0:VERTEX_LIMIT-1];
    logic [VERT_W-1:0]      vert_new_index [0:VERTEX_LIMIT-1];
    logic [NEW_INDEX_W-1:0] next_vertex_index;
    int                     faces_done;
    int                     cfg_faces;
    int                     cfg_verts;

    out_item_t pending_faces[$];
    out_item_t want;
    int        mismatches;
    int        items_applied;
    int        faces_checked;
    int        faces_kept;
    int        restarts;
    int        idle_pct;
    int        stall_cycles;

    always #4 clk = ~clk;

    task automatic note_mismatch(input string what, input int unsigned exp_val,
                                 input int unsigned act_val);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, exp_val, act_val);
    endtask

    function automatic int faces_limit();
        return (cfg_faces < FACE_LIMIT) ? cfg_faces : FACE_LIMIT;
    endfunction

    function automatic int verts_limit();
        return (cfg_verts < VERTEX_LIMIT) ? cfg_verts : VERTEX_LIMIT;
    endfunction

    // Work out the effect of one accepted item and queue the face result.
    task automatic predict_remap(input in_item_t it);
        out_item_t         exp_res;
        logic [VERT_W-1:0] corner [3];
        logic [VERT_W-1:0] renum [3];
        logic [2:0]        fresh;
        bit                bad;
        case (it.kind)
            KIND_MARK:
            begin
                if (!it.remove_index[REMOVE_W-1] && int'(it.remove_index) < faces_limit())
                begin
                    face_removed[int'(it.remove_index)] = 1'b1;
                    items_applied++;
                end
            end
            KIND_RESTART:
            begin
                face_removed      = '{default: 1'b0};
                vert_mapped       = '{default: 1'b0};
                next_vertex_index = '0;
                faces_done        = 0;
                restarts++;
                items_applied++;
            end
            KIND_FACE:
            begin
                items_applied++;
                exp_res = '0;
                exp_res.face_number = faces_done[FACE_NUM_W-1:0];
                if (faces_done >= faces_limit())
                    exp_res.status = STATUS_FACE_RANGE;
                else if (face_removed[faces_done])
                    faces_done++;
                else
                begin
                    corner[0] = it.corner_a;
                    corner[1] = it.corner_b;
                    corner[2] = it.corner_c;
                    bad = 1'b0;
                    for (int j = 0; j < 3; j++)
                        if (int'(corner[j]) >= verts_limit())
                            bad = 1'b1;
                    if (bad)
                        exp_res.status = STATUS_VERTEX_RANGE;
                    else
                    begin
                        fresh = '0;
                        for (int j = 0; j < 3; j++)
                        begin
                            if (!vert_mapped[corner[j]])
                            begin
                                vert_new_index[corner[j]] = next_vertex_index[VERT_W-1:0];
                                vert_mapped[corner[j]]    = 1'b1;
                                next_vertex_index = next_vertex_index + NEW_INDEX_W'(1);
                                fresh[j]                  = 1'b1;
                            end
                            renum[j] = vert_new_index[corner[j]];
                        end
                        exp_res.kept         = 1'b1;
                        exp_res.new_corner_a = renum[0];
                        exp_res.new_corner_b = renum[1];
                        exp_res.new_corner_c = renum[2];
                        exp_res.fresh_mask   = fresh;
                        faces_done++;
                    end
                end
                pending_faces.insert(pending_faces.size(), exp_res);
            end
            default: ;
        endcase
    endtask

    // One transfer on the command side; start stays high on return.
    task automatic send_item(input in_item_t it);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_remap(it);
    endtask

    // Drop start and wait for the block to go quiet.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_faces.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned value);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] data;
        mask = (addr[2] == REG_VERTEX_COUNT) ? (1 << VERTEX_COUNT_W) - 1
                                             : (1 << FACE_COUNT_W) - 1;
        data = value & mask;
        if ($urandom_range(0, 3) == 0)
            data = data | ($urandom & ~mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr[2] == REG_VERTEX_COUNT)
            cfg_verts = data & mask;
        else
            cfg_faces = data & mask;
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if ((prdata & mask) != (data & mask))
            note_mismatch("register read-back", data & mask, prdata & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_item_t make_item(input logic [KIND_W-1:0] kind, input int rem,
                                           input int a, input int b, input int c);
        in_item_t it;
        it.kind         = kind;
        it.remove_index = rem[REMOVE_W-1:0];
        it.corner_a     = a[VERT_W-1:0];
        it.corner_b     = b[VERT_W-1:0];
        it.corner_c     = c[VERT_W-1:0];
        return it;
    endfunction

    function automatic in_item_t noise_item(input logic [KIND_W-1:0] kind);
        return make_item(kind, $urandom_range(0, 65535), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095));
    endfunction

    // Corners mostly from a window of valid vertices, so reuse is common.
    function automatic int pick_corner(input int lo, input int span, input int lim);
        if (lim == 0 || $urandom_range(0, 99) < 8)
            return $urandom_range(0, 4095);
        return lo + $urandom_range(0, ((span < lim) ? span : lim) - 1);
    endfunction

    task automatic test_face_beyond_count();
        settle();
        write_reg(ADDR_FACE_COUNT, 0);
        write_reg(ADDR_VERTEX_COUNT, 0);
        send_item(make_item(KIND_FACE, 0, 0, 0, 0));
        send_item(make_item(KIND_MARK, 0, 0, 0, 0));
        send_item(make_item(KIND_FACE, 0, 4095, 4095, 4095));
    endtask

    task automatic test_renumbering();
        settle();
        write_reg(ADDR_FACE_COUNT, 16383);
        write_reg(ADDR_VERTEX_COUNT, 8191);
        send_item(make_item(KIND_RESTART, 0, 0, 0, 0));
        send_item(make_item(KIND_FACE, 0, 0, 4095, 0));
        send_item(make_item(KIND_FACE, 0, 4095, 7, 7));
        send_item(make_item(KIND_UNUSED, -1, 4095, 4095, 4095));
        send_item(make_item(KIND_FACE, 0, 2730, 1365, 4095));
    endtask

    task automatic test_removal_marks();
        settle();
        write_reg(ADDR_FACE_COUNT, 5);
        write_reg(ADDR_VERTEX_COUNT, 3);
        send_item(make_item(KIND_RESTART, 0, 0, 0, 0));
        send_item(make_item(KIND_MARK, -32768, 0, 0, 0));
        send_item(make_item(KIND_MARK, 32767, 0, 0, 0));
        send_item(make_item(KIND_MARK, 5, 0, 0, 0));
        send_item(make_item(KIND_MARK, 4, 0, 0, 0));
        send_item(make_item(KIND_MARK, 1, 0, 0, 0));
        send_item(make_item(KIND_FACE, 0, 0, 1, 2));
        send_item(make_item(KIND_FACE, 0, 4095, 4095, 4095));
        // marking a face already processed must not change anything
        send_item(make_item(KIND_MARK, 0, 0, 0, 0));
        send_item(make_item(KIND_FACE, 0, 2, 1, 0));
        send_item(make_item(KIND_FACE, 0, 0, 0, 0));
        send_item(make_item(KIND_FACE, 0, 1, 1, 1));
        send_item(make_item(KIND_FACE, 0, 0, 1, 2));
    endtask

    task automatic test_vertex_range();
        settle();
        write_reg(ADDR_VERTEX_COUNT, 0);
        send_item(make_item(KIND_RESTART, 0, 0, 0, 0));
        send_item(make_item(KIND_FACE, 0, 0, 0, 0));
        settle();
        write_reg(ADDR_VERTEX_COUNT, 10);
        send_item(make_item(KIND_FACE, 0, 9, 10, 9));
        send_item(make_item(KIND_FACE, 0, 9, 9, 0));
    endtask

    // One mesh: new register values, restart, marks, then the face stream.
    task automatic run_mesh_phase(input int phase_idle);
        int       r;
        int       flim;
        int       vlim;
        int       n_marks;
        int       n_faces;
        int       span;
        int       lo;
        int       a;
        int       b;
        int       c;
        in_item_t it;
        settle();
        r = $urandom_range(0, 9);
        a = (r == 0) ? 0 : (r == 1) ? $urandom_range(8192, 16383) : $urandom_range(1, 160);
        r = $urandom_range(0, 9);
        b = (r == 0) ? 0 : (r == 1) ? $urandom_range(4096, 8191) : $urandom_range(3, 400);
        if ($urandom_range(0, 1))
        begin
            write_reg(ADDR_FACE_COUNT, a);
            write_reg(ADDR_VERTEX_COUNT, b);
        end
        else
        begin
            write_reg(ADDR_VERTEX_COUNT, b);
            write_reg(ADDR_FACE_COUNT, a);
        end
        flim     = faces_limit();
        vlim     = verts_limit();
        idle_pct = phase_idle;
        send_item(noise_item(KIND_RESTART));
        n_marks = $urandom_range(0, ((flim < 120) ? flim : 120) / 3);
        for (int i = 0; i < n_marks; i++)
        begin
            it = noise_item(KIND_MARK);
            if ($urandom_range(0, 9) != 0 && flim > 0)
                it.remove_index = REMOVE_W'($urandom_range(0, flim - 1));
            send_item(it);
        end
        n_faces = $urandom_range(40, 160);
        if (flim < n_faces)
            n_faces = flim + $urandom_range(1, 3);
        span = $urandom_range(4, 64);
        lo   = (vlim > span) ? $urandom_range(0, vlim - span) : 0;
        for (int i = 0; i < n_faces; i++)
        begin
            r = $urandom_range(0, 399);
            if (r < 12)
                send_item(noise_item(KIND_UNUSED));
            else if (r < 24)
            begin
                it = noise_item(KIND_MARK);
                if (r < 20 && flim > 0)
                    it.remove_index = REMOVE_W'($urandom_range(0, flim - 1));
                send_item(it);
            end
            else if (r == 24)
                send_item(noise_item(KIND_RESTART));
            a = pick_corner(lo, span, vlim);
            b = pick_corner(lo, span, vlim);
            c = pick_corner(lo, span, vlim);
            r = $urandom_range(0, 9);
            if (r == 0)
                b = a;
            else if (r == 1)
                c = a;
            else if (r == 2)
                c = b;
            send_item(make_item(KIND_FACE, $urandom_range(0, 65535), a, b, c));
        end
    endtask

    task automatic test_random_meshes();
        int target;
        target = items_applied + RANDOM_ITEMS;
        while (items_applied < target)
        begin
            case ($urandom_range(0, 2))
                0: run_mesh_phase(0);
                1: run_mesh_phase(12);
                default: run_mesh_phase(40);
            endcase
        end
    endtask

    task automatic test_back_to_back();
        int target;
        target = items_applied + STREAM_ITEMS;
        while (items_applied < target)
            run_mesh_phase(0);
    endtask

    // result checker: the receiver cannot stall, take every strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_faces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result for face %0d with nothing pending", result.face_number);
            end
            else
            begin
                want = pending_faces.pop_front();
                faces_checked++;
                if (want.kept)
                    faces_kept++;
                if (result.face_number !== want.face_number)
                    note_mismatch("face_number", want.face_number, result.face_number);
                if (result.kept !== want.kept)
                    note_mismatch("kept", want.kept, result.kept);
                if (result.status !== want.status)
                    note_mismatch("status", want.status, result.status);
                if (result.new_corner_a !== want.new_corner_a)
                    note_mismatch("new_corner_a", want.new_corner_a, result.new_corner_a);
                if (result.new_corner_b !== want.new_corner_b)
                    note_mismatch("new_corner_b", want.new_corner_b, result.new_corner_b);
                if (result.new_corner_c !== want.new_corner_c)
                    note_mismatch("new_corner_c", want.new_corner_c, result.new_corner_c);
                if (result.fresh_mask !== want.fresh_mask)
                    note_mismatch("fresh_mask", want.fresh_mask, result.fresh_mask);
            end
        end
    end

    // watchdog: the clearing pass after a restart is the longest quiet stretch
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", pending_faces.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        start             = 1'b0;
        item              = '0;
        face_removed      = '{default: 1'b0};
        vert_mapped       = '{default: 1'b0};
        vert_new_index    = '{default: '0};
        next_vertex_index = '0;
        faces_done        = 0;
        cfg_faces         = 0;
        cfg_verts         = 0;
        mismatches        = 0;
        items_applied     = 0;
        faces_checked     = 0;
        faces_kept        = 0;
        restarts          = 0;
        idle_pct          = 25;
        stall_cycles      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_face_beyond_count();
        test_renumbering();
        test_removal_marks();
        test_vertex_range();
        test_random_meshes();
        test_back_to_back();
        settle();

        $display("applied %0d items over %0d restarts; checked %0d face results, %0d kept",
                 items_applied, restarts, faces_checked, faces_kept);
        $display("register extremes, removal marks, bad vertices and excess faces exercised");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/frvr_pkg.sv
hw/rtl/frvr_cfg.sv
hw/rtl/face_removal_vertex_remap.sv
sim/tb_top.sv
